/* rtl/core/inplace_centered_moving_average_defines.svh */
// ----------------------------------------------------------------------------
// inplace_centered_moving_average_defines
// assertion macros shared by the filter modules
// ----------------------------------------------------------------------------
`ifndef INPLACE_CENTERED_MOVING_AVERAGE_DEFINES_SVH
`define INPLACE_CENTERED_MOVING_AVERAGE_DEFINES_SVH

// property that holds at every edge out of reset
`define ICMA_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// same-cycle implication
`define ICMA_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ICMA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/icma_pkg.sv */
// ----------------------------------------------------------------------------
// icma_pkg
// types and constants of the in-place centered moving average filter
// ----------------------------------------------------------------------------
`default_nettype none

package icma_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int CFG_W      = 6;
  localparam int FILL_W     = 6;
  localparam int RESULT_CAP = 32;
  localparam int SUM_W      = 22;

  localparam logic [CFG_W-1:0] WINDOW_RESET = 6'd5;

  typedef enum logic [1:0] {
    OP_PASS,
    OP_STORE,
    OP_STORE_EMIT
  } icma_op_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       is_last;
    icma_op_t                   op;
  } icma_cmd_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] filtered;
    logic                       end_of_record;
  } icma_res_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_WRITE,
    BK_SUM,
    BK_DIV,
    BK_WBACK,
    BK_HEAD,
    BK_EMIT
  } icma_bk_state_t;

endpackage

`default_nettype wire

/* rtl/core/icma_fifo.sv */
// ----------------------------------------------------------------------------
// icma_fifo
// two-entry request queue with full and empty flags
// ----------------------------------------------------------------------------
`default_nettype none
`include "inplace_centered_moving_average_defines.svh"

module icma_fifo #(
  parameter int W = 1
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] wr_data,
  output logic              full,
  input  wire logic         pop,
  output logic [W-1:0]      rd_data,
  output logic              empty
);

  localparam int DEPTH = 2;
  localparam int PW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wp_r, wp_nxt;
  logic [PW-1:0] rp_r, rp_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_data = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? wp_r + PW'(1) : wp_r;
    rp_nxt  = pop ? rp_r + PW'(1) : rp_r;
    cnt_nxt = cnt_r;
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + CW'(1);
      2'b01:   cnt_nxt = cnt_r - CW'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  `ICMA_ASSERT_ALWAYS(a_cnt_range, cnt_r <= CW'(DEPTH), "queue count over depth")
  `ICMA_ASSERT_IMPLY(a_no_overflow, push, !full || pop, "push into full queue")
  `ICMA_ASSERT_IMPLY(a_no_underflow, pop, !empty, "pop from empty queue")

endmodule

`default_nettype wire

/* rtl/core/icma_front.sv */
// ----------------------------------------------------------------------------
// icma_front
// window register, record tracking and request classification
// ----------------------------------------------------------------------------
`default_nettype none

module icma_front
  import icma_pkg::*;
#(
  parameter int MAX_WINDOW = 32
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_wr_en,
  input  wire logic [CFG_W-1:0]           cfg_wr_data,
  input  wire logic                       in_push,
  input  wire logic signed [SAMPLE_W-1:0] in_sample,
  input  wire logic                       in_is_last,
  input  wire logic                       cq_full,
  output logic                            cq_push,
  output icma_cmd_t                       cq_cmd
);

  localparam int CAP = (MAX_WINDOW < RESULT_CAP) ? MAX_WINDOW : RESULT_CAP;

  logic [CFG_W-1:0]  win_r;
  logic [FILL_W-1:0] fcnt_r, fcnt_nxt;
  logic [FILL_W-1:0] act_r, act_nxt;
  logic [FILL_W-1:0] p_eff;
  logic [FILL_W-1:0] act;
  logic [FILL_W-1:0] f_inc;
  logic              full_win;

  assign cq_push = in_push && !cq_full;

  always_comb begin
    p_eff    = (FILL_W'(win_r) > FILL_W'(CAP)) ? FILL_W'(CAP) : FILL_W'(win_r);
    act      = (fcnt_r == '0) ? p_eff : act_r;
    f_inc    = fcnt_r + FILL_W'(1);
    full_win = (f_inc >= act);
    fcnt_nxt = fcnt_r;
    act_nxt  = act_r;
    cq_cmd.sample  = in_sample;
    cq_cmd.is_last = in_is_last;
    if (act == '0) begin
      cq_cmd.op = OP_PASS;
    end else if (full_win) begin
      cq_cmd.op = OP_STORE_EMIT;
    end else begin
      cq_cmd.op = OP_STORE;
    end
    if (cq_push) begin
      act_nxt = act;
      if (act == '0 || in_is_last) begin
        fcnt_nxt = '0;
      end else if (full_win) begin
        fcnt_nxt = fcnt_r;
      end else begin
        fcnt_nxt = f_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r  <= WINDOW_RESET;
      fcnt_r <= '0;
      act_r  <= '0;
    end else begin
      if (cfg_wr_en) begin
        win_r <= cfg_wr_data;
      end
      fcnt_r <= fcnt_nxt;
      act_r  <= act_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/icma_back.sv */
// ----------------------------------------------------------------------------
// icma_back
// sample store, serial window sum, restoring divider and in-place write back
// ----------------------------------------------------------------------------
`default_nettype none
`include "inplace_centered_moving_average_defines.svh"

module icma_back
  import icma_pkg::*;
#(
  parameter int MAX_WINDOW = 32
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      cq_empty,
  input  wire icma_cmd_t cq_cmd,
  output logic           cq_pop,
  input  wire logic      oq_full,
  output logic           oq_push,
  output icma_res_t      oq_res
);

  localparam int AW  = $clog2(MAX_WINDOW);
  localparam int CAP = (MAX_WINDOW < RESULT_CAP) ? MAX_WINDOW : RESULT_CAP;
  localparam logic [FILL_W-1:0] DIV_LAST = FILL_W'(SUM_W - 1);

  function automatic logic [AW-1:0] slot(input logic [AW-1:0] h,
                                         input logic [FILL_W-1:0] off);
    logic [AW:0] s;
    s = {1'b0, h} + (AW+1)'(off);
    if (s >= (AW+1)'(MAX_WINDOW)) begin
      s = s - (AW+1)'(MAX_WINDOW);
    end
    return s[AW-1:0];
  endfunction

  logic signed [SAMPLE_W-1:0] mem [MAX_WINDOW];
  logic signed [SAMPLE_W-1:0] rdata_r;

  icma_bk_state_t st_r, st_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [AW-1:0]     head_r, head_nxt;
  logic [FILL_W-1:0] k_r, k_nxt;
  logic [FILL_W-1:0] cnt_r, cnt_nxt;
  logic              pend_r, pend_nxt;

  logic signed [SAMPLE_W-1:0] samp_r, samp_nxt;
  logic                       last_r, last_nxt;
  logic                       pass_r, pass_nxt;
  logic                       emit_r, emit_nxt;
  logic signed [SUM_W-1:0]    acc_r, acc_nxt;
  logic [SUM_W-1:0]           q_r, q_nxt;
  logic [FILL_W:0]            rem_r, rem_nxt;
  logic                       neg_r, neg_nxt;

  logic                       we;
  logic [AW-1:0]              wa;
  logic signed [SAMPLE_W-1:0] wd;
  logic [AW-1:0]              ra;
  logic [FILL_W:0]            trial;
  logic [SAMPLE_W-1:0]        quo;

  always_comb begin
    quo = neg_r ? (SAMPLE_W'(0) - q_r[SAMPLE_W-1:0]) : q_r[SAMPLE_W-1:0];
    trial = {rem_r[FILL_W-1:0], q_r[SUM_W-1]};
    oq_res.filtered      = pass_r ? samp_r : rdata_r;
    oq_res.end_of_record = pass_r ? last_r : (last_r && fill_r == FILL_W'(1));
  end

  always_comb begin
    st_nxt   = st_r;
    fill_nxt = fill_r;
    head_nxt = head_r;
    k_nxt    = k_r;
    cnt_nxt  = cnt_r;
    pend_nxt = 1'b0;
    samp_nxt = samp_r;
    last_nxt = last_r;
    pass_nxt = pass_r;
    emit_nxt = emit_r;
    acc_nxt  = acc_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    neg_nxt  = neg_r;
    cq_pop   = 1'b0;
    oq_push  = 1'b0;
    we       = 1'b0;
    wa       = slot(head_r, fill_r);
    wd       = samp_r;
    ra       = head_r;
    unique case (st_r)
      BK_IDLE: begin
        if (!cq_empty) begin
          cq_pop   = 1'b1;
          samp_nxt = cq_cmd.sample;
          last_nxt = cq_cmd.is_last;
          pass_nxt = (cq_cmd.op == OP_PASS);
          emit_nxt = (cq_cmd.op == OP_STORE_EMIT);
          st_nxt   = (cq_cmd.op == OP_PASS) ? BK_EMIT : BK_WRITE;
        end
      end
      BK_WRITE: begin
        we       = 1'b1;
        fill_nxt = fill_r + FILL_W'(1);
        if (emit_r || last_r) begin
          k_nxt   = fill_r + FILL_W'(1);
          cnt_nxt = '0;
          acc_nxt = '0;
          st_nxt  = BK_SUM;
        end else begin
          st_nxt = BK_IDLE;
        end
      end
      BK_SUM: begin
        ra = slot(head_r, cnt_r);
        if (cnt_r < k_r) begin
          cnt_nxt  = cnt_r + FILL_W'(1);
          pend_nxt = 1'b1;
        end
        if (pend_r) begin
          acc_nxt = acc_r + SUM_W'(rdata_r);
        end
        if (cnt_r == k_r && !pend_r) begin
          neg_nxt = acc_r[SUM_W-1];
          q_nxt   = acc_r[SUM_W-1] ? (SUM_W'(0) - acc_r) : acc_r;
          rem_nxt = '0;
          cnt_nxt = '0;
          st_nxt  = BK_DIV;
        end
      end
      BK_DIV: begin
        if (trial >= {1'b0, k_r}) begin
          rem_nxt = trial - {1'b0, k_r};
          q_nxt   = {q_r[SUM_W-2:0], 1'b1};
        end else begin
          rem_nxt = trial;
          q_nxt   = {q_r[SUM_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + FILL_W'(1);
        if (cnt_r == DIV_LAST) begin
          st_nxt = BK_WBACK;
        end
      end
      BK_WBACK: begin
        we     = 1'b1;
        wa     = slot(head_r, k_r >> 1);
        wd     = quo;
        st_nxt = BK_HEAD;
      end
      BK_HEAD: begin
        st_nxt = BK_EMIT;
      end
      BK_EMIT: begin
        if (!oq_full) begin
          oq_push = 1'b1;
          if (pass_r) begin
            st_nxt = BK_IDLE;
          end else begin
            fill_nxt = fill_r - FILL_W'(1);
            head_nxt = slot(head_r, FILL_W'(1));
            if (last_r && fill_r != FILL_W'(1)) begin
              k_nxt   = fill_r - FILL_W'(1);
              cnt_nxt = '0;
              acc_nxt = '0;
              st_nxt  = BK_SUM;
            end else begin
              if (last_r) begin
                head_nxt = '0;
              end
              st_nxt = BK_IDLE;
            end
          end
        end
      end
      default: begin
        st_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= BK_IDLE;
      fill_r <= '0;
      head_r <= '0;
      pend_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      fill_r <= fill_nxt;
      head_r <= head_nxt;
      pend_r <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r    <= k_nxt;
    cnt_r  <= cnt_nxt;
    samp_r <= samp_nxt;
    last_r <= last_nxt;
    pass_r <= pass_nxt;
    emit_r <= emit_nxt;
    acc_r  <= acc_nxt;
    q_r    <= q_nxt;
    rem_r  <= rem_nxt;
    neg_r  <= neg_nxt;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rdata_r <= mem[ra];
  end

  `ICMA_ASSERT_ALWAYS(a_fill_cap, fill_r <= FILL_W'(CAP), "buffer fill over capacity")
  `ICMA_ASSERT_IMPLY(a_sum_bounds, st_r == BK_SUM, k_r != '0 && cnt_r <= k_r, "bad window sum count")
  `ICMA_ASSERT_NEXT(a_emit_drop, st_r == BK_EMIT && !oq_full && !pass_r && !last_r, st_r == BK_IDLE && fill_r == $past(fill_r) - FILL_W'(1), "window emit did not drop head")
  `ICMA_ASSERT_NEXT(a_flush_end, st_r == BK_EMIT && !oq_full && !pass_r && last_r && fill_r == FILL_W'(1), head_r == '0 && fill_r == '0, "record end left buffer state")

endmodule

`default_nettype wire

/* rtl/core/inplace_centered_moving_average.sv */
// a request that completes a window of k samples holds the back end for a serial sum over
// the sample store, then a restoring divider
// a request that only stores goes through the write state, a pass-through request straight to emit
// the last request of a record then runs the sum and divider per remaining window of k samples
// synchronous active-low reset clears control state and sets the window length to 5
// the sample store is not cleared, since only entries of the current record are read
// ----------------------------------------------------------------------------
// inplace_centered_moving_average
// streaming in-place centered moving average over records of signed samples
// ----------------------------------------------------------------------------
`default_nettype none

module inplace_centered_moving_average
  import icma_pkg::*;
#(
  parameter int MAX_WINDOW = 32
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_wr_en,
  input  wire logic [CFG_W-1:0]           cfg_wr_data,
  input  wire logic                       in_push,
  output logic                            in_full,
  input  wire logic signed [SAMPLE_W-1:0] in_sample,
  input  wire logic                       in_is_last,
  output logic                            out_empty,
  input  wire logic                       out_pop,
  output logic signed [SAMPLE_W-1:0]      out_filtered,
  output logic                            out_end_of_record
);

  localparam int CMD_W = $bits(icma_cmd_t);
  localparam int RES_W = $bits(icma_res_t);

  logic             cq_push;
  logic             cq_full;
  logic             cq_pop;
  logic             cq_empty;
  icma_cmd_t        cq_wr_cmd;
  logic [CMD_W-1:0] cq_rd_data;
  icma_cmd_t        cq_rd_cmd;

  logic             oq_push;
  logic             oq_full;
  icma_res_t        oq_wr_res;
  logic [RES_W-1:0] oq_rd_data;
  icma_res_t        oq_rd_res;

  assign in_full           = cq_full;
  assign cq_rd_cmd         = cq_rd_data;
  assign oq_rd_res         = oq_rd_data;
  assign out_filtered      = oq_rd_res.filtered;
  assign out_end_of_record = oq_rd_res.end_of_record;

  icma_front #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_push     (in_push),
    .in_sample   (in_sample),
    .in_is_last  (in_is_last),
    .cq_full     (cq_full),
    .cq_push     (cq_push),
    .cq_cmd      (cq_wr_cmd)
  );

  icma_fifo #(
    .W (CMD_W)
  ) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (cq_push),
    .wr_data (cq_wr_cmd),
    .full    (cq_full),
    .pop     (cq_pop),
    .rd_data (cq_rd_data),
    .empty   (cq_empty)
  );

  icma_back #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cq_empty (cq_empty),
    .cq_cmd   (cq_rd_cmd),
    .cq_pop   (cq_pop),
    .oq_full  (oq_full),
    .oq_push  (oq_push),
    .oq_res   (oq_wr_res)
  );

  icma_fifo #(
    .W (RES_W)
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (oq_push),
    .wr_data (oq_wr_res),
    .full    (oq_full),
    .pop     (out_pop && !out_empty),
    .rd_data (oq_rd_data),
    .empty   (out_empty)
  );

endmodule

`default_nettype wire
